// ===== hw/rtl/wrrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrp_pkg
// Shared types and constants for the weighted round-robin picker.
// ----------------------------------------------------------------------------

package wrrp_pkg;

    localparam int MAX_INSTANCES_DEF = 64;
    localparam int WEIGHT_IN_W       = 16;
    localparam int WEIGHT_W          = 15;
    localparam int CTR_W             = 64;
    localparam int BIT_CNT_W         = 6;
    localparam int INDEX_OUT_W       = 6;
    localparam int TDATA_IN_W        = 16;
    localparam int TDATA_OUT_W       = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_FIN
    } state_t;

    // clamp a raw weight to the range 1..32767
    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_IN_W-1:0] raw);
        logic [WEIGHT_W-1:0] w;
        if (raw[WEIGHT_IN_W-1] || (raw == '0))
            w = WEIGHT_W'(1);
        else
            w = raw[WEIGHT_W-1:0];
        return w;
    endfunction

endpackage

// ===== hw/rtl/wrrp_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrp_alu
// Shared subtract/compare unit: used for the restoring modulo steps and for
// the cumulative weight walk.
// ----------------------------------------------------------------------------

module wrrp_alu #(
    parameter int W = 22
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         lt
);

    logic [W:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[W-1:0];
    assign lt   = full[W];

endmodule

// ===== hw/rtl/wrrp_weight_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrp_weight_ram
// Weight store: one write port, one registered read port.
// ----------------------------------------------------------------------------

module wrrp_weight_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 15
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/weighted_round_robin_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_picker
// Weighted round-robin pick over a streamed list of candidate weights.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one candidate weight per transaction; tlast marks the last
//   candidate of a list. Weights below 1 count as 1. Up to MAX_INSTANCES
//   entries are stored; further ones are dropped and flagged.
//   Non-last transactions are taken one per cycle while no pick is running.
//   A last transaction starts a pick: a bit-serial modulo of the
//   pick counter by the weight sum, then a walk of the weight store with
//   a RAM read and then a compare/subtract for each entry, all on one
//   shared subtractor. s_axis_tready is low during the pick.
//   m_axis carries the chosen index and the overflow flag; one transaction
//   per list. The result is held in an output register; a stalled receiver
//   does not block loading of the next list, but a following pick waits at
//   its end until the previous result is taken.
//   Reset clears the list state, the pick counter and the output valid.
// ----------------------------------------------------------------------------

module weighted_round_robin_picker #(
    parameter int MAX_INSTANCES = wrrp_pkg::MAX_INSTANCES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wrrp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // [15:0] weight
    input  logic                             s_axis_tlast,   // last_entry
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wrrp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // [5:0] chosen_index, [7:6] zero
    output logic                             m_axis_tuser    // overflow
);

    localparam int CNT_W = $clog2(MAX_INSTANCES + 1);
    localparam int IDX_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int SUM_W = wrrp_pkg::WEIGHT_W + CNT_W;
    localparam int ALU_W = SUM_W + 1;

    wrrp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic                             ovf_reg, ovf_next;
    logic [wrrp_pkg::CTR_W-1:0]       ctr_reg, ctr_next;
    logic [wrrp_pkg::CTR_W-1:0]       div_reg, div_next;
    logic [SUM_W-1:0]                 rem_reg, rem_next;
    logic [wrrp_pkg::BIT_CNT_W-1:0]   bit_reg, bit_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [wrrp_pkg::INDEX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic                             out_ovf_reg, out_ovf_next;
    logic                             m_valid_reg, m_valid_next;

    logic                        in_ready;
    logic                        in_fire;
    logic                        out_free;
    logic                        rd_en;
    logic                        mod_sel;
    logic [wrrp_pkg::WEIGHT_W-1:0] w_clamped;
    logic                        wr_en;
    logic [wrrp_pkg::WEIGHT_W-1:0] rd_data;
    logic [ALU_W-1:0]            alu_a, alu_b, alu_diff;
    logic                        alu_lt;
    logic                        walk_end;

    assign w_clamped = wrrp_pkg::clamp_weight(s_axis_tdata);
    assign in_fire   = s_axis_tvalid && in_ready;
    assign wr_en     = in_fire && (cnt_reg < CNT_W'(MAX_INSTANCES));
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign walk_end  = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    wrrp_weight_ram #(
        .DEPTH (MAX_INSTANCES),
        .AW    (IDX_W),
        .DW    (wrrp_pkg::WEIGHT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (w_clamped),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (mod_sel)
        begin
            alu_a = {rem_reg, div_reg[wrrp_pkg::CTR_W-1]};
            alu_b = {1'b0, sum_reg};
        end
        else
        begin
            alu_a = {1'b0, rem_reg};
            alu_b = ALU_W'(rd_data);
        end
    end

    wrrp_alu #(
        .W (ALU_W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .lt   (alu_lt)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wrrp_pkg::ST_IDLE:
            begin
                if (in_fire && s_axis_tlast)
                    state_next = wrrp_pkg::ST_MOD;
            end
            wrrp_pkg::ST_MOD:
            begin
                if (bit_reg == '0)
                    state_next = wrrp_pkg::ST_WALK_RD;
            end
            wrrp_pkg::ST_WALK_RD:
            begin
                state_next = wrrp_pkg::ST_WALK_CMP;
            end
            wrrp_pkg::ST_WALK_CMP:
            begin
                if (alu_lt || walk_end)
                    state_next = wrrp_pkg::ST_FIN;
                else
                    state_next = wrrp_pkg::ST_WALK_RD;
            end
            wrrp_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = wrrp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = wrrp_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        mod_sel  = 1'b0;
        case (state_reg)
            wrrp_pkg::ST_IDLE:     in_ready = 1'b1;
            wrrp_pkg::ST_MOD:      mod_sel  = 1'b1;
            wrrp_pkg::ST_WALK_RD:  rd_en    = 1'b1;
            wrrp_pkg::ST_WALK_CMP: mod_sel  = 1'b0;
            wrrp_pkg::ST_FIN:      in_ready = 1'b0;
            default:               in_ready = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        ctr_next     = ctr_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        idx_next     = idx_reg;
        out_idx_next = out_idx_reg;
        out_ovf_next = out_ovf_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            wrrp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (wr_en)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        sum_next = sum_reg + SUM_W'(w_clamped);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        div_next = ctr_reg;
                        ctr_next = ctr_reg + wrrp_pkg::CTR_W'(1);
                        rem_next = '0;
                        bit_next = wrrp_pkg::BIT_CNT_W'(wrrp_pkg::CTR_W - 1);
                    end
                end
            end
            wrrp_pkg::ST_MOD:
            begin
                if (alu_lt)
                    rem_next = alu_a[SUM_W-1:0];
                else
                    rem_next = alu_diff[SUM_W-1:0];
                div_next = {div_reg[wrrp_pkg::CTR_W-2:0], 1'b0};
                bit_next = bit_reg - wrrp_pkg::BIT_CNT_W'(1);
                idx_next = '0;
            end
            wrrp_pkg::ST_WALK_CMP:
            begin
                if (alu_lt)
                begin
                    idx_next = idx_reg;
                end
                else if (walk_end)
                begin
                    idx_next = '0;
                end
                else
                begin
                    rem_next = alu_diff[SUM_W-1:0];
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            wrrp_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_idx_next = wrrp_pkg::INDEX_OUT_W'(idx_reg);
                    out_ovf_next = ovf_reg;
                    m_valid_next = 1'b1;
                    cnt_next     = '0;
                    sum_next     = '0;
                    ovf_next     = 1'b0;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wrrp_pkg::ST_IDLE;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            ctr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            ovf_reg     <= ovf_next;
            ctr_reg     <= ctr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        idx_reg     <= idx_next;
        out_idx_reg <= out_idx_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = wrrp_pkg::TDATA_OUT_W'(out_idx_reg);
    assign m_axis_tuser  = out_ovf_reg;

endmodule

// ===== tb/weighted_round_robin_picker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_picker_tb
// Self-checking bench for the weighted round-robin picker.
// ----------------------------------------------------------------------------
// Streams candidate lists into s_axis and tracks the pick counter, stored
// weights and overflow in a local model. Every m_axis transaction is checked
// against the oldest predicted pick. A directed set comes first: weight
// extremes, clamping of zero and negatives, small mixed lists, then a
// full-capacity list and over-capacity lists. It is followed by random
// lists of mostly short length, with some long and some over-capacity
// lists. Both sides take random idle bursts except near the end of the run.
// ----------------------------------------------------------------------------

module weighted_round_robin_picker_tb;

    localparam int MAX_ENTRIES  = wrrp_pkg::MAX_INSTANCES_DEF;
    localparam int TOTAL_ITEMS  = 1050;
    localparam int TAIL_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 250;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [wrrp_pkg::WEIGHT_IN_W-1:0] weight;
        logic                             last;
    } cand_t;

    typedef struct packed {
        logic [wrrp_pkg::INDEX_OUT_W-1:0] idx;
        logic                             ovf;
    } pick_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [wrrp_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [wrrp_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;

    cand_t cand_queue[$];
    pick_t expected_picks[$];
    cand_t in_flight;

    // model state
    logic [wrrp_pkg::WEIGHT_W-1:0] stored_w [0:MAX_ENTRIES-1];
    int unsigned                   list_len = 0;
    logic [20:0]                   w_total = '0;
    logic [wrrp_pkg::CTR_W-1:0]    pick_ctr = '0;
    bit                            list_ovf = 1'b0;

    int  send_gap = 0;
    int  recv_stall = 0;
    bit  tail_quiet = 1'b0;
    int  errors = 0;
    int  items_accepted = 0;
    int  lists_sent = 0;
    int  picks_checked = 0;
    int  ovf_picks = 0;
    int  max_idx_seen = 0;
    int  cycle_count = 0;

    always #6 clk = ~clk;

    weighted_round_robin_picker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic add_item(input logic [wrrp_pkg::WEIGHT_IN_W-1:0] w, input logic last);
        cand_t c;
        c.weight = w;
        c.last   = last;
        cand_queue.push_back(c);
        if (last)
            lists_sent++;
    endtask

    function automatic logic [wrrp_pkg::WEIGHT_IN_W-1:0] rand_weight();
        logic [wrrp_pkg::WEIGHT_IN_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w = wrrp_pkg::WEIGHT_IN_W'($urandom_range(1, 4));
            5:             w = '0;
            6:             w = {1'b1, 15'($urandom)};
            7:             w = 16'h7FFF;
            default:       w = 16'($urandom);
        endcase
        return w;
    endfunction

    // clamp, store and sum; on the list end compute the pick
    task automatic predict_pick(input cand_t c);
        logic [wrrp_pkg::WEIGHT_W-1:0] w;
        logic [wrrp_pkg::CTR_W-1:0]    cursor;
        pick_t                         p;
        if (c.weight[wrrp_pkg::WEIGHT_IN_W-1] || c.weight == '0)
            w = wrrp_pkg::WEIGHT_W'(1);
        else
            w = c.weight[wrrp_pkg::WEIGHT_W-1:0];
        if (list_len < MAX_ENTRIES)
        begin
            stored_w[list_len] = w;
            list_len++;
            w_total += 21'(w);
        end
        else
        begin
            list_ovf = 1'b1;
        end
        if (c.last)
        begin
            cursor = pick_ctr % wrrp_pkg::CTR_W'(w_total);
            pick_ctr++;
            p.idx = '0;
            for (int i = 0; i < list_len; i++)
            begin
                if (cursor < wrrp_pkg::CTR_W'(stored_w[i]))
                begin
                    p.idx = wrrp_pkg::INDEX_OUT_W'(i);
                    break;
                end
                cursor -= wrrp_pkg::CTR_W'(stored_w[i]);
            end
            p.ovf = list_ovf;
            expected_picks.push_back(p);
            list_len = 0;
            w_total  = '0;
            list_ovf = 1'b0;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_pick(in_flight);
            items_accepted++;
        end
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 16'($urandom);
            end
            else if (cand_queue.size() > 0)
            begin
                if (!tail_quiet && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    in_flight = cand_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.weight;
                    s_axis_tlast  <= in_flight.last;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        tail_quiet <= (cand_queue.size() < TAIL_ITEMS);
    end

    // monitor and receiver backpressure
    always @(posedge clk)
    begin
        pick_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_picks.size() == 0)
            begin
                $display("[%0t] unexpected result: idx %0d ovf %0b", $time,
                         m_axis_tdata[5:0], m_axis_tuser);
                errors++;
            end
            else
            begin
                want = expected_picks.pop_front();
                picks_checked++;
                if (m_axis_tdata[5:0] !== want.idx)
                begin
                    $display("[%0t] chosen_index mismatch: expected %0d actual %0d",
                             $time, want.idx, m_axis_tdata[5:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.ovf)
                begin
                    $display("[%0t] overflow mismatch: expected %0b actual %0b",
                             $time, want.ovf, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:6] !== 2'b00)
                begin
                    $display("[%0t] tdata pad mismatch: expected 0 actual %0b",
                             $time, m_axis_tdata[7:6]);
                    errors++;
                end
                if (want.ovf)
                    ovf_picks++;
                if (int'(want.idx) > max_idx_seen)
                    max_idx_seen = int'(want.idx);
            end
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (!tail_quiet && $urandom_range(0, 6) == 0)
        begin
            recv_stall = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d picks outstanding", $time,
                     cycle_count, expected_picks.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int  r;
        int  len;
        bit  unit;

        // single-entry lists at the weight extremes
        add_item(16'h0000, 1'b1);
        add_item(16'h0001, 1'b1);
        add_item(16'hFFFF, 1'b1);
        add_item(16'h8000, 1'b1);
        add_item(16'h7FFF, 1'b1);
        // short mixed lists
        add_item(16'h7FFF, 1'b0);
        add_item(16'h0001, 1'b1);
        add_item(16'h0001, 1'b0);
        add_item(16'h0001, 1'b0);
        add_item(16'h0001, 1'b1);
        add_item(16'h0000, 1'b0);
        add_item(16'h8000, 1'b0);
        add_item(16'hFFFF, 1'b0);
        add_item(16'h0002, 1'b1);
        add_item(16'h5555, 1'b0);
        add_item(16'h2AAA, 1'b1);
        add_item(16'h0003, 1'b0);
        add_item(16'h0001, 1'b0);
        add_item(16'h0002, 1'b0);
        add_item(16'h0004, 1'b1);

        // full capacity, last beyond capacity, long overflow
        for (int k = 0; k < MAX_ENTRIES; k++)
            add_item(16'h0001, k == MAX_ENTRIES - 1);
        for (int k = 0; k <= MAX_ENTRIES; k++)
            add_item(16'h0001, k == MAX_ENTRIES);
        for (int k = 0; k < 80; k++)
            add_item(rand_weight(), k == 79);

        while (cand_queue.size() < TOTAL_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 90)
                len = $urandom_range(7, 20);
            else if (r < 97)
                len = $urandom_range(21, MAX_ENTRIES);
            else
                len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 16);
            unit = (len > 20) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < len; k++)
                add_item(unit ? 16'h0001 : rand_weight(), k == len - 1);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (cand_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d candidates in %0d lists; %0d picks checked.",
                 items_accepted, lists_sent, picks_checked);
        $display("Over-capacity lists: %0d; highest index picked: %0d.",
                 ovf_picks, max_idx_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wrrp_pkg.sv
hw/rtl/wrrp_alu.sv
hw/rtl/wrrp_weight_ram.sv
hw/rtl/weighted_round_robin_picker.sv
tb/weighted_round_robin_picker_tb.sv
